// File: hw/rtl/pwg_pkg.sv
package pwg_pkg;

   // fixed field widths
   localparam int DATA_WIDTH     = 32;
   localparam int GAIN_WIDTH     = 24;
   localparam int LIMIT_WIDTH    = 31;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = 3 * DATA_WIDTH;

   // datapath latency from input register to result register
   localparam int PIPE_STAGES = 7;

   // register indexes
   localparam logic [2:0] REG_GAIN_P         = 3'd0;
   localparam logic [2:0] REG_GAIN_I         = 3'd1;
   localparam logic [2:0] REG_GAIN_D         = 3'd2;
   localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd3;
   localparam logic [2:0] REG_OUTPUT_MAX     = 3'd4;
   localparam logic [2:0] REG_OUTPUT_MIN     = 3'd5;
   localparam logic [2:0] REG_DAMPING_MODE   = 3'd6;
   localparam logic [2:0] REG_RATE_INVERT    = 3'd7;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [GAIN_WIDTH-1:0]        gain_type;

   typedef struct packed {
      gain_type               gain_p;
      gain_type               gain_i;
      gain_type               gain_d;
      logic [LIMIT_WIDTH-1:0] integral_limit;
      data_type               output_max;
      data_type               output_min;
      logic                   damping_mode;
      logic                   rate_sign_invert;
   } cfg_type;

   typedef struct packed {
      data_type drive;
      logic     clamped;
   } result_type;

endpackage

// File: hw/rtl/pwg_datapath.sv
module pwg_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  pwg_pkg::cfg_type    cfg,
   input  logic                in_valid,
   input  pwg_pkg::data_type   setpoint,
   input  pwg_pkg::data_type   measured,
   input  pwg_pkg::data_type   rate,
   output logic                out_valid,
   output pwg_pkg::result_type result
);
   import pwg_pkg::*;

   localparam int WIDE       = DATA_WIDTH + 3;
   localparam int PROD_WIDTH = DATA_WIDTH + GAIN_WIDTH;
   localparam int MAG_WIDTH  = PROD_WIDTH - FRAC_BITS;

   localparam data_type DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [WIDE-1:0] WMAX = WIDE'(DMAX);
   localparam logic signed [WIDE-1:0] WMIN = WIDE'(DMIN);
   localparam data_type ONE_Q     = data_type'(64'(1) << FRAC_BITS);
   localparam data_type NEG_ONE_Q = -ONE_Q;
   localparam logic [PROD_WIDTH-1:0] HALF_Q = PROD_WIDTH'(64'(1) << (FRAC_BITS - 1));
   localparam logic [MAG_WIDTH-1:0] MAG_MAX = MAG_WIDTH'(DMAX);
   localparam logic [MAG_WIDTH-1:0] MAG_NEG_MAX = MAG_MAX + MAG_WIDTH'(1);

   function automatic logic signed [WIDE-1:0] widen(input data_type x);
      return WIDE'(x);
   endfunction

   function automatic data_type sat_wide(input logic signed [WIDE-1:0] v);
      data_type r;
      if (v > WMAX) r = DMAX;
      else if (v < WMIN) r = DMIN;
      else r = data_type'(v[DATA_WIDTH-1:0]);
      return r;
   endfunction

   function automatic logic [DATA_WIDTH-1:0] magnitude(input data_type x);
      return x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
   endfunction

   // gain * |x| rounded half up, then shifted down
   function automatic logic [MAG_WIDTH-1:0] round_prod(input gain_type g,
                                                       input logic [DATA_WIDTH-1:0] m);
      logic [PROD_WIDTH-1:0] p;
      p = PROD_WIDTH'(m) * PROD_WIDTH'(g) + HALF_Q;
      return p[PROD_WIDTH-1:FRAC_BITS];
   endfunction

   function automatic data_type apply_sign(input logic [MAG_WIDTH-1:0] r, input logic neg);
      logic [DATA_WIDTH-1:0] low;
      data_type              v;
      low = r[DATA_WIDTH-1:0];
      if (neg) v = (r > MAG_NEG_MAX) ? DMIN : data_type'(~low + 1'b1);
      else     v = (r > MAG_MAX) ? DMAX : data_type'(low);
      return v;
   endfunction

   logic [PIPE_STAGES-1:0] vld_ff, vld_in;

   data_type s1_sp_ff, s1_meas_ff, s1_rate_ff;
   data_type s2_err_ff, s2_rate_ff, s2_err_in, s2_rate_in;
   data_type s3_err_ff, s3_dop_ff, s3_dop_in;
   data_type prev_err_ff;
   logic [MAG_WIDTH-1:0] s4_p_mag_ff, s4_i_mag_ff, s4_d_mag_ff;
   logic                 s4_err_neg_ff, s4_dop_neg_ff;
   data_type s5_p_ff, s5_i_ff, s5_d_ff;
   data_type integ_ff, integ_in, integ_lim;
   data_type s6_p_ff, s6_i_ff, s6_i_in;
   logic signed [WIDE-1:0] s6_d_ff, s6_d_in;
   data_type s7_drive_ff, sum_in, drive_in;
   logic     s7_clamped_ff, clamped_in;

   assign vld_in = {vld_ff[PIPE_STAGES-2:0], in_valid};

   // error saturates, small rates fall in the dead band
   assign s2_err_in  = sat_wide(widen(s1_sp_ff) - widen(s1_meas_ff));
   assign s2_rate_in = ($signed(s1_rate_ff) > NEG_ONE_Q && $signed(s1_rate_ff) < ONE_Q)
                       ? '0 : s1_rate_ff;

   // derivative operand: error change in pid mode, gyro rate otherwise
   assign s3_dop_in = cfg.damping_mode ? s2_rate_ff
                                       : sat_wide(widen(s2_err_ff) - widen(prev_err_ff));

   // integral update with symmetric anti-windup clamp
   always_comb begin
      integ_lim = data_type'(DATA_WIDTH'(cfg.integral_limit));
      integ_in  = sat_wide(widen(integ_ff) + widen(s5_i_ff));
      if ($signed(integ_in) > $signed(integ_lim)) integ_in = integ_lim;
      if ($signed(integ_in) < -$signed(integ_lim)) integ_in = -integ_lim;
   end

   assign s6_i_in = cfg.damping_mode ? '0 : integ_in;
   assign s6_d_in = (cfg.damping_mode && !cfg.rate_sign_invert) ? -widen(s5_d_ff)
                                                                : widen(s5_d_ff);

   // upper clamp first, then lower
   always_comb begin
      sum_in     = sat_wide(widen(s6_p_ff) + widen(s6_i_ff) + s6_d_ff);
      drive_in   = sum_in;
      clamped_in = 1'b0;
      if ($signed(drive_in) > $signed(cfg.output_max)) begin
         drive_in   = cfg.output_max;
         clamped_in = 1'b1;
      end
      if ($signed(drive_in) < $signed(cfg.output_min)) begin
         drive_in   = cfg.output_min;
         clamped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         prev_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         vld_ff <= vld_in;
         if (vld_ff[1]) prev_err_ff <= s2_err_ff;
         if (vld_ff[4] && !cfg.damping_mode) integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sp_ff      <= setpoint;
      s1_meas_ff    <= measured;
      s1_rate_ff    <= rate;
      s2_err_ff     <= s2_err_in;
      s2_rate_ff    <= s2_rate_in;
      s3_err_ff     <= s2_err_ff;
      s3_dop_ff     <= s3_dop_in;
      s4_p_mag_ff   <= round_prod(cfg.gain_p, magnitude(s3_err_ff));
      s4_i_mag_ff   <= round_prod(cfg.gain_i, magnitude(s3_err_ff));
      s4_d_mag_ff   <= round_prod(cfg.gain_d, magnitude(s3_dop_ff));
      s4_err_neg_ff <= s3_err_ff[DATA_WIDTH-1];
      s4_dop_neg_ff <= s3_dop_ff[DATA_WIDTH-1];
      s5_p_ff       <= apply_sign(s4_p_mag_ff, s4_err_neg_ff);
      s5_i_ff       <= apply_sign(s4_i_mag_ff, s4_err_neg_ff);
      s5_d_ff       <= apply_sign(s4_d_mag_ff, s4_dop_neg_ff);
      s6_p_ff       <= s5_p_ff;
      s6_i_ff       <= s6_i_in;
      s6_d_ff       <= s6_d_in;
      s7_drive_ff   <= drive_in;
      s7_clamped_ff <= clamped_in;
   end

   assign out_valid      = vld_ff[PIPE_STAGES-1];
   assign result.drive   = s7_drive_ff;
   assign result.clamped = s7_clamped_ff;

endmodule

// File: hw/rtl/pid_with_gyro_damping_top.sv
// positional pid controller with anti-windup integral clamp and a gyro damping mode.
// one req beat carries setpoint, measured and rate (signed q16.16); one rsp beat comes
// back per req beat, in order, with the clamped drive and a clamp flag. in pid mode the
// drive is p + i + d, the integral gathering gain_i * error clamped to +/- integral_limit
// and d being gain_d times the change in error; in gyro mode it is p minus the damping
// term gain_d * rate (sign flipped by rate_sign_invert), with rates below 1.0 in
// magnitude ignored and the integral held. the block takes one beat per clock cycle
// while req_tready is high; each beat passes 7 registers in the datapath (input
// register, error, operand select, multiply, saturate, integral update, sum and clamp)
// and is then written into the result queue, which raises rsp_tvalid. a 16-entry result
// queue behind the datapath absorbs rsp stalls; req_tready drops once 16 beats are
// accepted and not yet taken. registers sit at byte address 4*index and should only be
// written while idle.
module pid_with_gyro_damping_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // setpoint [31:0], measured [63:32], rate [95:64]
   input  logic [pwg_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // drive [31:0]
   output logic [pwg_pkg::DATA_WIDTH-1:0]      rsp_tdata,
   // clamped [0]
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pwg_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pwg_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pwg_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import pwg_pkg::*;

   localparam int FIFO_DEPTH = 16;
   localparam int PTR_WIDTH  = $clog2(FIFO_DEPTH);
   localparam int CNT_WIDTH  = PTR_WIDTH + 1;

   // register file
   cfg_type    cfg_ff;
   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p           <= GAIN_WIDTH'(144179);
         cfg_ff.gain_i           <= '0;
         cfg_ff.gain_d           <= GAIN_WIDTH'(7864);
         cfg_ff.integral_limit   <= LIMIT_WIDTH'(196608);
         cfg_ff.output_max       <= DATA_WIDTH'(2949120);
         cfg_ff.output_min       <= DATA_WIDTH'(-2949120);
         cfg_ff.damping_mode     <= 1'b0;
         cfg_ff.rate_sign_invert <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_GAIN_P:         cfg_ff.gain_p           <= csr_pwdata[GAIN_WIDTH-1:0];
            REG_GAIN_I:         cfg_ff.gain_i           <= csr_pwdata[GAIN_WIDTH-1:0];
            REG_GAIN_D:         cfg_ff.gain_d           <= csr_pwdata[GAIN_WIDTH-1:0];
            REG_INTEGRAL_LIMIT: cfg_ff.integral_limit   <= csr_pwdata[LIMIT_WIDTH-1:0];
            REG_OUTPUT_MAX:     cfg_ff.output_max       <= csr_pwdata[DATA_WIDTH-1:0];
            REG_OUTPUT_MIN:     cfg_ff.output_min       <= csr_pwdata[DATA_WIDTH-1:0];
            REG_DAMPING_MODE:   cfg_ff.damping_mode     <= csr_pwdata[0];
            REG_RATE_INVERT:    cfg_ff.rate_sign_invert <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_index)
         REG_GAIN_P:         csr_prdata = CSR_DATA_WIDTH'(cfg_ff.gain_p);
         REG_GAIN_I:         csr_prdata = CSR_DATA_WIDTH'(cfg_ff.gain_i);
         REG_GAIN_D:         csr_prdata = CSR_DATA_WIDTH'(cfg_ff.gain_d);
         REG_INTEGRAL_LIMIT: csr_prdata = CSR_DATA_WIDTH'(cfg_ff.integral_limit);
         REG_OUTPUT_MAX:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.output_max);
         REG_OUTPUT_MIN:     csr_prdata = CSR_DATA_WIDTH'(cfg_ff.output_min);
         REG_DAMPING_MODE:   csr_prdata = CSR_DATA_WIDTH'(cfg_ff.damping_mode);
         REG_RATE_INVERT:    csr_prdata = CSR_DATA_WIDTH'(cfg_ff.rate_sign_invert);
         default:            csr_prdata = '0;
      endcase
   end

   // datapath
   logic       req_accept;
   logic       dp_valid;
   result_type dp_result;

   assign req_accept = req_tvalid & req_tready;

   pwg_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_accept),
      .setpoint  (data_type'(req_tdata[DATA_WIDTH-1:0])),
      .measured  (data_type'(req_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
      .rate      (data_type'(req_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH])),
      .out_valid (dp_valid),
      .result    (dp_result)
   );

   // result queue; credit count covers beats in the datapath and in the queue
   result_type             fifo_mem [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_WIDTH-1:0]   fill_ff, fill_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   rsp_pop;

   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_pop    = rsp_tvalid & rsp_tready;
   assign rsp_tdata  = fifo_mem[rd_ptr_ff].drive;
   assign rsp_tuser  = fifo_mem[rd_ptr_ff].clamped;

   // no credit left, or in reset: hold off the req side
   assign req_tready = (count_ff < CNT_WIDTH'(FIFO_DEPTH)) & ~reset;

   assign fill_in  = fill_ff + CNT_WIDTH'(dp_valid) - CNT_WIDTH'(rsp_pop);
   assign count_in = count_ff + CNT_WIDTH'(req_accept) - CNT_WIDTH'(rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         count_ff  <= '0;
      end else begin
         if (dp_valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rsp_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_valid) fifo_mem[wr_ptr_ff] <= dp_result;
   end

`ifndef SYNTH
   // credits never exceed the queue size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(FIFO_DEPTH))
      else $error("credit count above queue depth");

   // queued results are a subset of outstanding beats
   a_fill_le_count: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= count_ff)
      else $error("queue holds more than outstanding beats");

   // each datapath result stems from a req beat a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      dp_valid |-> $past(req_accept, PIPE_STAGES))
      else $error("datapath result without matching req beat");

   // an offered rsp beat is always an outstanding one
   a_rsp_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (count_ff != '0))
      else $error("rsp beat offered with no outstanding beat");
`endif

endmodule

// File: sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import pwg_pkg::*;

   // fixed point helpers, q16.16 data and q8.16 gains
   localparam int      FRAC         = 16;
   localparam int      Q_ONE        = 1 << FRAC;
   localparam longint  DATA_MAX     = 64'sd2147483647;
   localparam longint  DATA_MIN     = -64'sd2147483648;
   localparam data_type VALUE_HI    = 32'sh7FFF_FFFF;
   localparam data_type VALUE_LO    = data_type'(32'h8000_0000);
   localparam gain_type GAIN_TOP    = 24'hFF_FFFF;
   localparam logic [30:0] LIMIT_TOP = 31'h7FFF_FFFF;

   // long receiver hold-off so the result queue fills and req_tready drops
   localparam int      HOLD_CYCLES  = 100;
   // cycles without any beat or register write before the run is abandoned
   localparam int      WATCHDOG_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid  = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata   = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready  = 1'b0;
   logic [DATA_WIDTH-1:0]     rsp_tdata;
   logic                      rsp_tuser;
   logic                      csr_psel    = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   // controller mirror: register copy plus integral and last error
   cfg_type    settings;
   longint     integral_acc = 0;
   longint     last_error   = 0;

   // drive values still owed by the block, oldest first
   result_type expected_drive_q[$];
   int         mismatches = 0;

   // pacing controls for the sender and the receiver, and the watchdog count
   bit         sender_burst   = 1'b0;
   bit         receiver_burst = 1'b0;
   int         rsp_wait       = 0;
   int         hold_left      = 0;
   int         holds_asked    = 0;
   int         holds_served   = 0;
   int         idle_cycles    = 0;

   pid_with_gyro_damping_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   function automatic longint clip(longint value);
      if (value > DATA_MAX) return DATA_MAX;
      if (value < DATA_MIN) return DATA_MIN;
      return value;
   endfunction

   // gain * value, rounded to nearest with ties away from zero, saturated
   function automatic longint scaled_product(gain_type gain, longint value);
      longint magnitude;
      longint product;
      magnitude = (value < 0) ? -value : value;
      product = (magnitude * longint'(gain) + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      return clip((value < 0) ? -product : product);
   endfunction

   function automatic result_type predict_control(data_type setpoint, data_type measured,
                                                  data_type rate);
      longint     err;
      longint     prop;
      longint     deriv;
      longint     total;
      longint     lim;
      longint     rate_term;
      result_type res;
      err  = clip(longint'(setpoint) - longint'(measured));
      prop = scaled_product(settings.gain_p, err);
      if (!settings.damping_mode) begin
         lim = longint'(settings.integral_limit);
         if (lim > DATA_MAX) lim = DATA_MAX;
         integral_acc = clip(integral_acc + scaled_product(settings.gain_i, err));
         if (integral_acc > lim)  integral_acc = lim;
         if (integral_acc < -lim) integral_acc = -lim;
         deriv = scaled_product(settings.gain_d, clip(err - last_error));
         total = clip(prop + integral_acc + deriv);
      end else begin
         // rates inside the dead band count as zero, 1.0 itself passes
         rate_term = longint'(rate);
         if (rate_term > -Q_ONE && rate_term < Q_ONE) rate_term = 0;
         deriv = scaled_product(settings.gain_d, rate_term);
         if (!settings.rate_sign_invert) deriv = -deriv;
         total = clip(prop + deriv);
      end
      // upper clamp first, then lower: crossed limits end at output_min
      res.clamped = 1'b0;
      if (total > longint'(settings.output_max)) begin
         total = longint'(settings.output_max);
         res.clamped = 1'b1;
      end
      if (total < longint'(settings.output_min)) begin
         total = longint'(settings.output_min);
         res.clamped = 1'b1;
      end
      last_error = err;
      res.drive = data_type'(total);
      return res;
   endfunction

   // ------------------------------------------------------------------
   // bus drivers, all called at a falling edge
   // ------------------------------------------------------------------

   // one apb write: setup, access, then idle
   task automatic write_register(logic [2:0] index, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_GAIN_P:         settings.gain_p           = value[GAIN_WIDTH-1:0];
         REG_GAIN_I:         settings.gain_i           = value[GAIN_WIDTH-1:0];
         REG_GAIN_D:         settings.gain_d           = value[GAIN_WIDTH-1:0];
         REG_INTEGRAL_LIMIT: settings.integral_limit   = value[LIMIT_WIDTH-1:0];
         REG_OUTPUT_MAX:     settings.output_max       = data_type'(value);
         REG_OUTPUT_MIN:     settings.output_min       = data_type'(value);
         REG_DAMPING_MODE:   settings.damping_mode     = value[0];
         REG_RATE_INVERT:    settings.rate_sign_invert = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // offer one control sample; the expectation is formed on acceptance
   task automatic send_sample(data_type setpoint, data_type measured, data_type rate);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rate, measured, setpoint};
      do @(posedge clock); while (!req_tready);
      expected_drive_q.push_back(predict_control(setpoint, measured, rate));
      @(negedge clock);
   endtask

   // stop offering, collect every owed beat, let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_drive_q.size() != 0) @(negedge clock);
      repeat (PIPE_STAGES + 1) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // random value sources
   // ------------------------------------------------------------------

   function automatic data_type pick_value();
      int span;
      case ($urandom_range(0, 5))
         0, 1: return data_type'($urandom);
         2: begin
            span = 1 << $urandom_range(4, 20);
            return data_type'(int'($urandom_range(0, 2 * span)) - span);
         end
         3: begin
            case ($urandom_range(0, 4))
               0:       return VALUE_HI;
               1:       return VALUE_LO;
               2:       return data_type'(0);
               3:       return data_type'(-1);
               default: return data_type'(1);
            endcase
         end
         // around the dead band edge
         4: return data_type'(($urandom_range(0, 1) ? -1 : 1) *
                              (Q_ONE + int'($urandom_range(0, 2)) - 1));
         default: begin
            span = 1 << 26;
            return data_type'(int'($urandom_range(0, 2 * span)) - span);
         end
      endcase
   endfunction

   function automatic gain_type pick_gain();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return GAIN_TOP;
         2:       return gain_type'($urandom);
         default: return gain_type'($urandom_range(0, 1 << 18));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // values right after reset: 2.2 / 0 / 0.12 gains, +-3.0 integral, +-45.0 output
   task automatic check_reset_settings();
      send_sample(data_type'(Q_ONE), data_type'(0), data_type'(0));
      send_sample(data_type'(10 * Q_ONE), data_type'(-20 * Q_ONE), data_type'(0));
      send_sample(data_type'(-30 * Q_ONE), data_type'(0), data_type'(0));
      wait_idle();
   endtask

   // full gains and full range: error and products saturate in both directions
   task automatic check_pid_extremes();
      write_register(REG_GAIN_P, 32'(GAIN_TOP));
      write_register(REG_GAIN_I, 32'(GAIN_TOP));
      write_register(REG_GAIN_D, 32'(GAIN_TOP));
      write_register(REG_INTEGRAL_LIMIT, 32'(LIMIT_TOP));
      write_register(REG_OUTPUT_MAX, 32'(VALUE_HI));
      write_register(REG_OUTPUT_MIN, 32'(VALUE_LO));
      write_register(REG_DAMPING_MODE, 32'd0);
      send_sample(VALUE_HI, VALUE_LO, VALUE_HI);
      send_sample(VALUE_LO, VALUE_HI, VALUE_LO);
      send_sample(data_type'(0), data_type'(0), data_type'(0));
      send_sample(VALUE_HI, data_type'(0), data_type'(-1));
      send_sample(data_type'(-1), data_type'(0), data_type'(1));
      wait_idle();
   endtask

   // half gain on one lsb: ties round away from zero on both signs
   task automatic check_rounding();
      write_register(REG_GAIN_P, 32'h0000_8000);
      write_register(REG_GAIN_I, 32'd0);
      write_register(REG_GAIN_D, 32'd0);
      send_sample(data_type'(1), data_type'(0), data_type'(0));
      send_sample(data_type'(0), data_type'(1), data_type'(0));
      wait_idle();
   endtask

   // integral alone, gain 1.0 and limit 2.0, windup held at both ends, then limit 0
   task automatic check_integral_clamp();
      write_register(REG_GAIN_P, 32'd0);
      write_register(REG_GAIN_I, 32'(Q_ONE));
      write_register(REG_INTEGRAL_LIMIT, 32'(2 * Q_ONE));
      send_sample(data_type'(3 * Q_ONE / 2), data_type'(0), data_type'(0));
      send_sample(data_type'(3 * Q_ONE / 2), data_type'(0), data_type'(0));
      send_sample(data_type'(0), data_type'(5 * Q_ONE), data_type'(0));
      send_sample(data_type'(0), data_type'(5 * Q_ONE), data_type'(0));
      wait_idle();
      write_register(REG_INTEGRAL_LIMIT, 32'd0);
      send_sample(data_type'(7 * Q_ONE), data_type'(0), data_type'(0));
      wait_idle();
   endtask

   // gyro mode: dead band edges, extreme rates, both damping signs
   task automatic check_gyro_damping();
      write_register(REG_DAMPING_MODE, 32'd1);
      write_register(REG_RATE_INVERT, 32'd0);
      write_register(REG_GAIN_D, 32'(Q_ONE));
      send_sample(data_type'(0), data_type'(0), data_type'(Q_ONE - 1));
      send_sample(data_type'(0), data_type'(0), data_type'(Q_ONE));
      send_sample(data_type'(0), data_type'(0), data_type'(1 - Q_ONE));
      send_sample(data_type'(0), data_type'(0), data_type'(-Q_ONE));
      send_sample(data_type'(0), data_type'(0), VALUE_LO);
      send_sample(data_type'(Q_ONE), data_type'(0), VALUE_HI);
      wait_idle();
      write_register(REG_RATE_INVERT, 32'd1);
      send_sample(data_type'(0), data_type'(0), data_type'(Q_ONE));
      send_sample(data_type'(0), data_type'(0), VALUE_LO);
      wait_idle();
   endtask

   // output_min above output_max: every drive lands on output_min
   task automatic check_crossed_limits();
      write_register(REG_DAMPING_MODE, 32'd0);
      write_register(REG_GAIN_P, 32'(Q_ONE));
      write_register(REG_OUTPUT_MAX, 32'(-Q_ONE));
      write_register(REG_OUTPUT_MIN, 32'(Q_ONE));
      send_sample(data_type'(0), data_type'(0), data_type'(0));
      send_sample(data_type'(5 * Q_ONE), data_type'(0), data_type'(0));
      wait_idle();
   endtask

   // new register set per phase; mode and sign follow the phase number
   task automatic load_random_settings(int phase);
      data_type a;
      data_type b;
      logic [30:0] lim;
      a = pick_value();
      b = pick_value();
      case ($urandom_range(0, 3))
         0:       lim = '0;
         1:       lim = LIMIT_TOP;
         2:       lim = 31'($urandom);
         default: lim = 31'($urandom_range(0, 1 << 22));
      endcase
      if ($urandom_range(0, 4) == 0) begin
         a = VALUE_HI;
         b = VALUE_LO;
      end
      // mostly ordered limits, sometimes crossed on purpose
      if ($urandom_range(0, 4) != 0 && a < b) begin
         a = a ^ b;
         b = a ^ b;
         a = a ^ b;
      end
      write_register(REG_GAIN_P, 32'(pick_gain()));
      write_register(REG_GAIN_I, 32'(pick_gain()));
      write_register(REG_GAIN_D, 32'(pick_gain()));
      write_register(REG_INTEGRAL_LIMIT, 32'(lim));
      write_register(REG_OUTPUT_MAX, 32'(a));
      write_register(REG_OUTPUT_MIN, 32'(b));
      write_register(REG_DAMPING_MODE, 32'(phase & 1));
      write_register(REG_RATE_INVERT, 32'((phase >> 1) & 1));
   endtask

   // phases of tracking runs (fixed setpoint, small wandering measurement) and noise
   task automatic run_random_traffic(int phases, int per_phase);
      data_type anchor;
      bit       tracking;
      bit       in_pressure;
      int       span;
      for (int phase = 0; phase < phases; phase++) begin
         load_random_settings(phase);
         for (int n = 0; n < per_phase; n++) begin
            in_pressure = (phase == 2) && (n >= 25) && (n < 75);
            if (n % 25 == 0) begin
               tracking = ($urandom_range(0, 3) != 0);
               anchor   = pick_value();
               receiver_burst = ($urandom_range(0, 3) == 0);
               sender_burst   = in_pressure ? 1'b1 : ($urandom_range(0, 3) == 0);
            end
            // receiver holds off while the sender keeps streaming
            if (phase == 2 && n == 25) holds_asked++;
            if (tracking) begin
               span = 1 << $urandom_range(8, 20);
               send_sample(anchor,
                           data_type'(anchor + (int'($urandom_range(0, 2 * span)) - span)),
                           data_type'(int'($urandom_range(0, 1 << 21)) - (1 << 20)));
            end else begin
               send_sample(pick_value(), pick_value(), pick_value());
            end
         end
         sender_burst   = 1'b0;
         receiver_burst = 1'b0;
         wait_idle();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      // register values after reset
      settings.gain_p           = 24'd144179;
      settings.gain_i           = 24'd0;
      settings.gain_d           = 24'd7864;
      settings.integral_limit   = 31'd196608;
      settings.output_max       = data_type'(2949120);
      settings.output_min       = data_type'(-2949120);
      settings.damping_mode     = 1'b0;
      settings.rate_sign_invert = 1'b0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      check_reset_settings();
      check_pid_extremes();
      check_rounding();
      check_integral_clamp();
      check_gyro_damping();
      check_crossed_limits();
      run_random_traffic(8, 100);

      // already drained by the last phase; a few more cycles for stray beats
      repeat (PIPE_STAGES + 4) @(posedge clock);
      if (mismatches == 0 && expected_drive_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   // ready pattern: long hold-off when asked, else a drawn stall per beat
   always @(negedge clock) begin
      if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each result beat with the oldest owed drive
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.drive   = data_type'(rsp_tdata);
         got.clamped = rsp_tuser;
         rsp_wait    = receiver_burst ? 0 : $urandom_range(0, 5);
         if (expected_drive_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat: drive %0d clamped %0b", got.drive, got.clamped);
         end else begin
            want = expected_drive_q.pop_front();
            if (got.drive !== want.drive || got.clamped !== want.clamped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp mismatch: expected drive %0d clamped %0b, got drive %0d clamped %0b",
                           want.drive, want.clamped, got.drive, got.clamped);
            end
         end
      end
   end

   // watchdog on cycles with no beat and no register access
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule

// File: filelist.f
hw/rtl/pwg_pkg.sv
hw/rtl/pwg_datapath.sv
hw/rtl/pid_with_gyro_damping_top.sv
sim/testbench.sv
